### rtl/priority_sorted_wait_queue_top_macros.svh
// assertion macros for the wait queue rtl
`ifndef PRIORITY_SORTED_WAIT_QUEUE_TOP_MACROS_SVH
`define PRIORITY_SORTED_WAIT_QUEUE_TOP_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define PSQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define PSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/psq_pkg.sv
// shared types and codes for the priority sorted wait queue
`default_nettype none

package psq_pkg;

    localparam int OPCODE_W = 2;
    localparam int THREAD_W = 4;
    localparam int PRIO_W   = 8;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [THREAD_W-1:0] removed_thread;
        logic                removed_valid;
        logic                queue_empty;
    } psq_result_t;

endpackage

`default_nettype wire

### rtl/psq_walker.sv
// list sequencer: link and priority memories walked one entry at a time
`default_nettype none

`include "priority_sorted_wait_queue_top_macros.svh"

module psq_walker #(
    parameter int NUM_THREADS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               idle,
    input  wire logic [psq_pkg::OPCODE_W-1:0]  opcode,
    input  wire logic [psq_pkg::THREAD_W-1:0]  thread_index,
    input  wire logic [psq_pkg::PRIO_W-1:0]    priority_req,
    output logic                               done,
    input  wire logic                          done_ack,
    output psq_pkg::psq_result_t               result
);

    localparam int IW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int LW = $clog2(NUM_THREADS + 1);
    localparam logic [LW-1:0] NONE_LINK = LW'(NUM_THREADS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HCMP  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_LINK1 = 4'd4;
    localparam logic [3:0] S_LINK2 = 4'd5;
    localparam logic [3:0] S_USUCC = 4'd6;
    localparam logic [3:0] S_UCHK  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                     state_reg, state_next;
    logic [LW-1:0]                  head_reg, head_next;
    logic [NUM_THREADS-1:0]         queued_reg, queued_next;
    logic [psq_pkg::OPCODE_W-1:0]   op_reg, op_next;
    logic [IW-1:0]                  t_reg, t_next;
    logic [psq_pkg::PRIO_W-1:0]     prio_reg, prio_next;
    logic [IW-1:0]                  cur_reg, cur_next;
    logic [IW-1:0]                  nxt_reg, nxt_next;
    logic [LW-1:0]                  link_reg, link_next;
    logic [LW-1:0]                  succ_reg, succ_next;
    logic                           at_head_reg, at_head_next;
    logic [psq_pkg::THREAD_W-1:0]   res_thread_reg, res_thread_next;
    logic                           res_valid_reg, res_valid_next;

    logic [LW-1:0]                  next_mem [NUM_THREADS];
    logic [psq_pkg::PRIO_W-1:0]     prio_mem [NUM_THREADS];
    logic [LW-1:0]                  nx_q_reg;
    logic [psq_pkg::PRIO_W-1:0]     pr_q_reg;

    logic                           nx_we;
    logic [IW-1:0]                  nx_waddr;
    logic [LW-1:0]                  nx_wdata;
    logic [IW-1:0]                  nx_raddr;
    logic                           pr_we;
    logic [IW-1:0]                  pr_waddr;
    logic [psq_pkg::PRIO_W-1:0]     pr_wdata;
    logic [IW-1:0]                  pr_raddr;

    logic                           t_ok;
    logic [IW-1:0]                  t_idx;
    logic                           head_none;
    logic [IW-1:0]                  head_idx;

    assign t_ok      = (int'(thread_index) < NUM_THREADS);
    assign t_idx     = IW'(thread_index);
    assign head_none = (head_reg >= NONE_LINK);
    assign head_idx  = head_reg[IW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        queued_next     = queued_reg;
        op_next         = op_reg;
        t_next          = t_reg;
        prio_next       = prio_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        link_next       = link_reg;
        succ_next       = succ_reg;
        at_head_next    = at_head_reg;
        res_thread_next = res_thread_reg;
        res_valid_next  = res_valid_reg;
        nx_we           = 1'b0;
        nx_waddr        = cur_reg;
        nx_wdata        = link_reg;
        nx_raddr        = cur_reg;
        pr_we           = 1'b0;
        pr_waddr        = t_idx;
        pr_wdata        = priority_req;
        pr_raddr        = head_idx;
        done            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = opcode;
                    res_thread_next = '0;
                    res_valid_next  = 1'b0;
                    state_next      = S_DONE;
                    unique case (opcode)
                        psq_pkg::OP_INSERT:
                        begin
                            if (t_ok && !queued_reg[t_idx])
                            begin
                                queued_next[t_idx] = 1'b1;
                                pr_we     = 1'b1;
                                t_next    = t_idx;
                                prio_next = priority_req;
                                if (head_none)
                                begin
                                    link_next    = NONE_LINK;
                                    at_head_next = 1'b1;
                                    state_next   = S_LINK1;
                                end
                                else
                                begin
                                    pr_raddr   = head_idx;
                                    state_next = S_HCMP;
                                end
                            end
                        end
                        psq_pkg::OP_POP:
                        begin
                            if (!head_none)
                            begin
                                res_thread_next       = psq_pkg::THREAD_W'(head_reg);
                                res_valid_next        = 1'b1;
                                queued_next[head_idx] = 1'b0;
                                t_next                = head_idx;
                                nx_raddr              = head_idx;
                                state_next            = S_USUCC;
                            end
                        end
                        psq_pkg::OP_REMOVE:
                        begin
                            if (t_ok && queued_reg[t_idx])
                            begin
                                res_valid_next     = 1'b1;
                                queued_next[t_idx] = 1'b0;
                                t_next             = t_idx;
                                nx_raddr           = t_idx;
                                state_next         = S_USUCC;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_HCMP:
            begin
                if (prio_reg < pr_q_reg)
                begin
                    link_next    = head_reg;
                    at_head_next = 1'b1;
                    state_next   = S_LINK1;
                end
                else
                begin
                    cur_next     = head_idx;
                    nx_raddr     = head_idx;
                    at_head_next = 1'b0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (nx_q_reg >= NONE_LINK)
                begin
                    link_next  = NONE_LINK;
                    state_next = S_LINK1;
                end
                else
                begin
                    nxt_next   = nx_q_reg[IW-1:0];
                    pr_raddr   = nx_q_reg[IW-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (prio_reg < pr_q_reg)
                begin
                    link_next  = LW'(nxt_reg);
                    state_next = S_LINK1;
                end
                else
                begin
                    cur_next   = nxt_reg;
                    nx_raddr   = nxt_reg;
                    state_next = S_CHECK;
                end
            end
            S_LINK1:
            begin
                nx_we    = 1'b1;
                nx_waddr = t_reg;
                nx_wdata = link_reg;
                if (at_head_reg)
                begin
                    head_next  = LW'(t_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LINK2;
                end
            end
            S_LINK2:
            begin
                nx_we      = 1'b1;
                nx_waddr   = cur_reg;
                nx_wdata   = LW'(t_reg);
                state_next = S_DONE;
            end
            S_USUCC:
            begin
                succ_next = nx_q_reg;
                if (head_reg == LW'(t_reg))
                begin
                    head_next  = nx_q_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = head_idx;
                    nx_raddr   = head_idx;
                    state_next = S_UCHK;
                end
            end
            S_UCHK:
            begin
                if (nx_q_reg == LW'(t_reg))
                begin
                    nx_we      = 1'b1;
                    nx_waddr   = cur_reg;
                    nx_wdata   = succ_reg;
                    state_next = S_DONE;
                end
                else if (nx_q_reg >= NONE_LINK)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next = nx_q_reg[IW-1:0];
                    nx_raddr = nx_q_reg[IW-1:0];
                end
            end
            S_DONE:
            begin
                done = 1'b1;
                if (done_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= NONE_LINK;
            queued_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            queued_reg <= queued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        t_reg          <= t_next;
        prio_reg       <= prio_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
        link_reg       <= link_next;
        succ_reg       <= succ_next;
        at_head_reg    <= at_head_next;
        res_thread_reg <= res_thread_next;
        res_valid_reg  <= res_valid_next;
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        nx_q_reg <= next_mem[nx_raddr];
    end

    // priority memory
    always_ff @(posedge clk)
    begin
        if (pr_we)
        begin
            prio_mem[pr_waddr] <= pr_wdata;
        end
        pr_q_reg <= prio_mem[pr_raddr];
    end

    assign idle                  = (state_reg == S_IDLE);
    assign result.removed_thread = res_thread_reg;
    assign result.removed_valid  = res_valid_reg;
    assign result.queue_empty    = head_none;

    `PSQ_ASSERT_NOW(a_head_queued, idle && !head_none, queued_reg[head_idx], "head thread not marked queued")
    `PSQ_ASSERT_NOW(a_empty_no_flags, idle && head_none, queued_reg == '0, "empty queue with queued flags")
    `PSQ_ASSERT_NOW(a_insert_no_removal, done && (op_reg == psq_pkg::OP_INSERT), !res_valid_reg, "insert reported a removal")
    `PSQ_ASSERT_NEXT(a_start_busy, start && idle, !idle, "sequencer stayed idle after a transfer")

endmodule

`default_nettype wire

### rtl/priority_sorted_wait_queue_top.sv
// Priority sorted wait queue. Threads are kept in a singly linked list ordered by priority,
// lower value first, equal priorities first in first out. One operation is taken at a time:
// in_ready is high only while the list sequencer is idle. A pop, an insert into an empty
// queue or ahead of the head needs no walk; any other insert walks the list, reading a link
// and a priority for each queued entry it passes, and a named removal of any thread but the
// head walks from the head to the entry ahead of it. The walk is set by the single read
// port of the link memory and the priority memory, each read with a registered output.
// Results leave through an output register, so the next walk runs while a result waits;
// that walk finishes only once the register is free.
`default_nettype none

module priority_sorted_wait_queue_top #(
    parameter int NUM_THREADS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [psq_pkg::OPCODE_W-1:0]  opcode,
    input  wire logic [psq_pkg::THREAD_W-1:0]  thread_index,
    input  wire logic [psq_pkg::PRIO_W-1:0]    priority_req,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [psq_pkg::THREAD_W-1:0]       removed_thread,
    output logic                               removed_valid,
    output logic                               queue_empty
);

    logic                   idle;
    logic                   start;
    logic                   done;
    logic                   done_ack;
    psq_pkg::psq_result_t   result;
    logic                   out_valid_reg, out_valid_next;
    psq_pkg::psq_result_t   out_reg, out_next;

    assign in_ready = idle;
    assign start    = in_valid && idle;
    assign done_ack = !out_valid_reg || out_ready;

    psq_walker #(
        .NUM_THREADS (NUM_THREADS)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .idle         (idle),
        .opcode       (opcode),
        .thread_index (thread_index),
        .priority_req (priority_req),
        .done         (done),
        .done_ack     (done_ack),
        .result       (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        priority if (done && done_ack)
        begin
            out_valid_next = 1'b1;
            out_next       = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign removed_thread = out_reg.removed_thread;
    assign removed_valid  = out_reg.removed_valid;
    assign queue_empty    = out_reg.queue_empty;

endmodule

`default_nettype wire

### sim/priority_sorted_wait_queue_top_tb.sv
// testbench for the priority sorted wait queue: random bursts of queue operations against a list predictor
`timescale 1ns / 100ps

module priority_sorted_wait_queue_top_tb;

    localparam int NUM_THREADS = 16;
    localparam bit [4:0] LINK_NONE = 5'(NUM_THREADS);
    localparam logic [psq_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_OPS = 790;

    typedef struct packed {
        bit [4:0]                                  head;
        bit [NUM_THREADS-1:0][4:0]                 next_link;
        bit [NUM_THREADS-1:0][psq_pkg::PRIO_W-1:0] prio;
        bit [NUM_THREADS-1:0]                      queued;
    } wait_list_t;

    typedef struct packed {
        bit [psq_pkg::OPCODE_W-1:0] op;
        bit [psq_pkg::THREAD_W-1:0] tid;
        bit [psq_pkg::PRIO_W-1:0]   pr;
        bit                         hold;
    } queue_op_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [psq_pkg::OPCODE_W-1:0] opcode = '0;
    logic [psq_pkg::THREAD_W-1:0] thread_index = '0;
    logic [psq_pkg::PRIO_W-1:0]   priority_req = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [psq_pkg::THREAD_W-1:0] removed_thread;
    logic                         removed_valid;
    logic                         queue_empty;

    queue_op_t            pending_ops[$];
    psq_pkg::psq_result_t expected_results[$];
    wait_list_t           gen_list;
    wait_list_t           model_list;
    int                   errors = 0;
    int                   checked = 0;
    int                   op_count[4] = '{0, 0, 0, 0};
    int                   deepest = 0;
    int                   burst_left = 1;
    int                   gap_left = 0;
    int                   stall_mode = 0;
    int                   mode_left = 0;
    int                   stall_left = 0;

    priority_sorted_wait_queue_top #(
        .NUM_THREADS(NUM_THREADS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .thread_index(thread_index),
        .priority_req(priority_req),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .removed_thread(removed_thread),
        .removed_valid(removed_valid),
        .queue_empty(queue_empty)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic wait_list_t empty_list();
        wait_list_t s;
        s.head = LINK_NONE;
        for (int i = 0; i < NUM_THREADS; i++)
        begin
            s.next_link[i] = LINK_NONE;
            s.prio[i] = '0;
            s.queued[i] = 1'b0;
        end
        return s;
    endfunction

    function automatic void unlink_thread(inout wait_list_t s,
                                          input bit [psq_pkg::THREAD_W-1:0] t);
        bit [4:0] prev;
        bit       done;
        done = 1'b0;
        if (s.head == {1'b0, t})
            s.head = s.next_link[t];
        else
        begin
            prev = s.head;
            for (int k = 0; k < NUM_THREADS && !done; k++)
            begin
                if (prev == LINK_NONE)
                    done = 1'b1;
                else if (s.next_link[prev[3:0]] == {1'b0, t})
                begin
                    s.next_link[prev[3:0]] = s.next_link[t];
                    done = 1'b1;
                end
                else
                    prev = s.next_link[prev[3:0]];
            end
        end
        s.next_link[t] = LINK_NONE;
        s.queued[t] = 1'b0;
    endfunction

    function automatic psq_pkg::psq_result_t list_step(inout wait_list_t s,
                                                       input bit [psq_pkg::OPCODE_W-1:0] op,
                                                       input bit [psq_pkg::THREAD_W-1:0] t,
                                                       input bit [psq_pkg::PRIO_W-1:0] pr);
        psq_pkg::psq_result_t res;
        bit [4:0]             prev;
        bit [4:0]             nxt;
        bit                   done;
        res = '0;
        done = 1'b0;
        if (op == psq_pkg::OP_INSERT && !s.queued[t])
        begin
            s.prio[t] = pr;
            s.queued[t] = 1'b1;
            s.next_link[t] = LINK_NONE;
            if (s.head == LINK_NONE)
                s.head = {1'b0, t};
            else if (pr < s.prio[s.head[3:0]])
            begin
                s.next_link[t] = s.head;
                s.head = {1'b0, t};
            end
            else
            begin
                prev = s.head;
                for (int k = 0; k < NUM_THREADS && !done; k++)
                begin
                    nxt = s.next_link[prev[3:0]];
                    if (nxt == LINK_NONE || pr < s.prio[nxt[3:0]])
                    begin
                        s.next_link[t] = nxt;
                        s.next_link[prev[3:0]] = {1'b0, t};
                        done = 1'b1;
                    end
                    else
                        prev = nxt;
                end
            end
        end
        else if (op == psq_pkg::OP_POP && s.head != LINK_NONE)
        begin
            res.removed_thread = s.head[3:0];
            res.removed_valid = 1'b1;
            unlink_thread(s, s.head[3:0]);
        end
        else if (op == psq_pkg::OP_REMOVE && s.queued[t])
        begin
            unlink_thread(s, t);
            res.removed_valid = 1'b1;
        end
        res.queue_empty = (s.head == LINK_NONE);
        return res;
    endfunction

    task automatic add_op(input bit [psq_pkg::OPCODE_W-1:0] op, input int t, input int pr,
                          input bit hold);
        queue_op_t item;
        item.op = op;
        item.tid = t[psq_pkg::THREAD_W-1:0];
        item.pr = pr[psq_pkg::PRIO_W-1:0];
        item.hold = hold;
        pending_ops.push_back(item);
        void'(list_step(gen_list, item.op, item.tid, item.pr));
    endtask

    function automatic int pick_thread(input bit want_queued);
        int t;
        t = $urandom_range(0, NUM_THREADS - 1);
        while (gen_list.queued[t] != want_queued)
            t = $urandom_range(0, NUM_THREADS - 1);
        return t;
    endfunction

    function automatic int pick_priority();
        case ($urandom_range(0, 2))
            0: return $urandom_range(0, 7);
            1: return $urandom_range(248, 255);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // sender: bursts of transfers with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        bit                   fire;
        psq_pkg::psq_result_t res;
        queue_op_t            item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= '0;
            thread_index <= '0;
            priority_req <= '0;
            model_list = empty_list();
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            fire = in_valid && in_ready;
            if (fire)
            begin
                res = list_step(model_list, opcode, thread_index, priority_req);
                expected_results.push_back(res);
                op_count[opcode]++;
                if ($countones(model_list.queued) > deepest)
                    deepest = $countones(model_list.queued);
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
                else
                    burst_left--;
            end
            if (!in_valid || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0 &&
                         (!pending_ops[0].hold || expected_results.size() == 0))
                begin
                    item = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    opcode <= item.op;
                    thread_index <= item.tid;
                    priority_req <= item.pr;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each transfer and stalls in changing patterns
    always @(posedge clk or negedge rst_n)
    begin
        psq_pkg::psq_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (removed_thread !== want.removed_thread)
                    begin
                        $error("removed_thread: expected %0d, got %0d",
                               want.removed_thread, removed_thread);
                        errors++;
                    end
                    if (removed_valid !== want.removed_valid)
                    begin
                        $error("removed_valid: expected %0d, got %0d",
                               want.removed_valid, removed_valid);
                        errors++;
                    end
                    if (queue_empty !== want.queue_empty)
                    begin
                        $error("queue_empty: expected %0d, got %0d",
                               want.queue_empty, queue_empty);
                        errors++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end
            else
                mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (stall_mode == 1 && $urandom_range(0, 2) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else if (stall_mode == 2 && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 39);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        int good_ops;
        int idx;
        int bias;
        int depth;
        int insert_pct;
        bit hold;

        gen_list = empty_list();

        // directed: empty queue cases, priority extremes, fifo among equals, removals everywhere
        add_op(psq_pkg::OP_POP, 9, 0, 1'b0);
        add_op(psq_pkg::OP_REMOVE, 5, 0, 1'b0);
        add_op(OP_UNUSED, 15, 255, 1'b0);
        add_op(psq_pkg::OP_INSERT, 0, 255, 1'b0);
        add_op(psq_pkg::OP_INSERT, 15, 0, 1'b0);
        add_op(psq_pkg::OP_INSERT, 7, 128, 1'b0);
        add_op(psq_pkg::OP_INSERT, 3, 128, 1'b0);
        add_op(psq_pkg::OP_INSERT, 9, 128, 1'b0);
        add_op(psq_pkg::OP_INSERT, 12, 255, 1'b0);
        add_op(psq_pkg::OP_INSERT, 7, 1, 1'b0);
        add_op(psq_pkg::OP_REMOVE, 3, 0, 1'b0);
        add_op(psq_pkg::OP_REMOVE, 12, 0, 1'b0);
        add_op(psq_pkg::OP_REMOVE, 15, 0, 1'b0);
        add_op(psq_pkg::OP_REMOVE, 3, 0, 1'b0);
        add_op(psq_pkg::OP_POP, 0, 255, 1'b0);
        add_op(psq_pkg::OP_POP, 15, 0, 1'b0);
        add_op(OP_UNUSED, 0, 0, 1'b0);
        add_op(psq_pkg::OP_POP, 6, 17, 1'b0);
        add_op(psq_pkg::OP_POP, 0, 0, 1'b0);
        add_op(psq_pkg::OP_INSERT, 15, 255, 1'b0);
        add_op(psq_pkg::OP_REMOVE, 15, 0, 1'b0);

        good_ops = 0;
        idx = 0;
        bias = 1;
        while (good_ops < RANDOM_OPS)
        begin
            if (idx % 60 == 0)
                bias = $urandom_range(0, 2);
            hold = (idx == 0) || ($urandom_range(0, 149) == 0);
            depth = $countones(gen_list.queued);
            if ($urandom_range(0, 99) < 10)
            begin
                case ($urandom_range(0, 3))
                    0: if (depth > 0)
                           add_op(psq_pkg::OP_INSERT, pick_thread(1'b1), pick_priority(), hold);
                       else
                           add_op(psq_pkg::OP_POP, $urandom_range(0, 15),
                                  $urandom_range(0, 255), hold);
                    1: if (depth < NUM_THREADS)
                           add_op(psq_pkg::OP_REMOVE, pick_thread(1'b0),
                                  $urandom_range(0, 255), hold);
                       else
                           add_op(psq_pkg::OP_POP, $urandom_range(0, 15),
                                  $urandom_range(0, 255), hold);
                    2: add_op(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 255), hold);
                    default: add_op(psq_pkg::OP_POP, $urandom_range(0, 15),
                                    $urandom_range(0, 255), hold);
                endcase
            end
            else
            begin
                insert_pct = (bias == 0) ? 75 : (bias == 1) ? 50 : 25;
                if (depth == 0 || (depth < NUM_THREADS && $urandom_range(0, 99) < insert_pct))
                    add_op(psq_pkg::OP_INSERT, pick_thread(1'b0), pick_priority(), hold);
                else if ($urandom_range(0, 1) == 0)
                    add_op(psq_pkg::OP_POP, $urandom_range(0, 15), $urandom_range(0, 255), hold);
                else
                    add_op(psq_pkg::OP_REMOVE, pick_thread(1'b1), $urandom_range(0, 255), hold);
                good_ops++;
            end
            idx++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d transfers: %0d inserts, %0d head pops, %0d named removals, %0d no-ops",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("checked %0d results, queue reached a depth of %0d threads", checked, deepest);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/psq_pkg.sv
rtl/psq_walker.sv
rtl/priority_sorted_wait_queue_top.sv
sim/priority_sorted_wait_queue_top_tb.sv
